[rtl/core/point_rotation_by_angle_assert.svh]
// Assertion macros used by the checker file of this block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef POINT_ROTATION_BY_ANGLE_ASSERT_SVH
`define POINT_ROTATION_BY_ANGLE_ASSERT_SVH

// Same-cycle implication.
`define PRA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point rotation assertion failed");

// Next-cycle implication.
`define PRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point rotation assertion failed");

`endif

[rtl/core/pra_pkg.sv]
`default_nettype none

package pra_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_SIZE    = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_SIZE) ? TABLE_SIZE : CORDIC_STAGES;
  localparam int SHIFT_W       = $clog2(TABLE_SIZE);

  localparam int ANGLE_WIDTH   = 17;
  localparam int ANGLE_EXT_W   = ANGLE_WIDTH + 1;
  localparam int FULL_TURN     = 46080;
  localparam int HALF_TURN     = 23040;
  localparam int QUARTER_TURN  = 11520;
  localparam int ANGLE_SHIFT   = 13;

  localparam int GUARD_BITS    = 16;
  localparam int GAIN_FRAC     = 30;
  localparam int GAIN_Q30      = 652032874;
  localparam int IN_SHIFT      = GAIN_FRAC - GUARD_BITS;

  // Working widths: coordinates carry the guard bits plus headroom for the
  // growth of the micro-rotations; the angle accumulator holds about 2^27.
  localparam int CEXT_W = COORD_WIDTH + 1;
  localparam int PROD_W = CEXT_W + GAIN_FRAC;
  localparam int XW     = COORD_WIDTH + GUARD_BITS + 4;
  localparam int ZW     = 30;
  localparam int RW     = XW - GUARD_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [ANGLE_EXT_W-1:0] angle_ext_t;
  typedef logic signed [CEXT_W-1:0]      coord_ext_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [XW-1:0]          work_t;
  typedef logic signed [ZW-1:0]          zang_t;
  typedef logic signed [RW-1:0]          round_t;
  typedef logic [SHIFT_W-1:0]            shift_t;

  typedef struct packed {
    work_t x;
    work_t y;
    zang_t z;
  } cordic_data_t;

  localparam angle_ext_t FULL_TURN_A    = angle_ext_t'(FULL_TURN);
  localparam angle_ext_t HALF_TURN_A    = angle_ext_t'(HALF_TURN);
  localparam angle_ext_t QUARTER_TURN_A = angle_ext_t'(QUARTER_TURN);

  localparam logic signed [GAIN_FRAC:0] GAIN_S   = (GAIN_FRAC + 1)'(GAIN_Q30);
  localparam prod_t                     ROUND_IN = prod_t'(1) <<< (IN_SHIFT - 1);
  localparam work_t                     ROUND_OUT = work_t'(1) <<< (GUARD_BITS - 1);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // atan(2^-i) in degrees, scaled by 2^20 and rounded to nearest.
  function automatic zang_t atan_deg(input shift_t idx);
    zang_t val;
    val = '0;
    unique case (idx)
      5'd0:    val = zang_t'(47185920);
      5'd1:    val = zang_t'(27855475);
      5'd2:    val = zang_t'(14718068);
      5'd3:    val = zang_t'(7471121);
      5'd4:    val = zang_t'(3750058);
      5'd5:    val = zang_t'(1876857);
      5'd6:    val = zang_t'(938658);
      5'd7:    val = zang_t'(469357);
      5'd8:    val = zang_t'(234682);
      5'd9:    val = zang_t'(117342);
      5'd10:   val = zang_t'(58671);
      5'd11:   val = zang_t'(29335);
      5'd12:   val = zang_t'(14668);
      5'd13:   val = zang_t'(7334);
      5'd14:   val = zang_t'(3667);
      5'd15:   val = zang_t'(1833);
      5'd16:   val = zang_t'(917);
      5'd17:   val = zang_t'(458);
      5'd18:   val = zang_t'(229);
      5'd19:   val = zang_t'(115);
      5'd20:   val = zang_t'(57);
      5'd21:   val = zang_t'(29);
      5'd22:   val = zang_t'(14);
      5'd23:   val = zang_t'(7);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pra_cfg_if.sv]
`default_nettype none

interface pra_cfg_if;
  logic            valid;
  logic            ready;
  pra_pkg::angle_t rotation_angle;

  modport source (output valid, output rotation_angle, input ready);
  modport sink   (input valid, input rotation_angle, output ready);
endinterface

`default_nettype wire

[rtl/core/pra_in_if.sv]
`default_nettype none

interface pra_in_if;
  logic            valid;
  logic            ready;
  pra_pkg::coord_t x_in;
  pra_pkg::coord_t y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

`default_nettype wire

[rtl/core/pra_out_if.sv]
`default_nettype none

interface pra_out_if;
  logic            valid;
  logic            ready;
  pra_pkg::coord_t x_out;
  pra_pkg::coord_t y_out;
  logic            clamped;

  modport source (output valid, output x_out, output y_out, output clamped, input ready);
  modport sink   (input valid, input x_out, input y_out, input clamped, output ready);
endinterface

`default_nettype wire

[rtl/core/pra_prep.sv]
`default_nettype none

// Front end: folds the angle into +-90 degrees, applies the half turn to the
// point, removes the CORDIC gain and rounds into the working format.
module pra_prep (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pra_pkg::angle_t       angle,
  input  wire logic                  up_valid,
  input  wire pra_pkg::coord_t       up_x,
  input  wire pra_pkg::coord_t       up_y,
  output logic                       up_ready,
  output logic                       dn_valid,
  output pra_pkg::cordic_data_t      dn_data,
  input  wire logic                  dn_ready
);

  pra_pkg::angle_ext_t a_ext;
  pra_pkg::angle_ext_t a_mod;
  pra_pkg::angle_ext_t a_fold;
  logic                flip;

  logic                 a_valid_r;
  pra_pkg::coord_ext_t  xa_r, ya_r;
  pra_pkg::zang_t       za_r;
  logic                 b_valid_r;
  pra_pkg::prod_t       xp_r, yp_r;
  pra_pkg::zang_t       zb_r;
  logic                 c_valid_r;
  pra_pkg::cordic_data_t data_c_r;

  pra_pkg::coord_ext_t  xa_nxt, ya_nxt;
  pra_pkg::zang_t       za_nxt;
  pra_pkg::prod_t       xp_nxt, yp_nxt;
  pra_pkg::cordic_data_t data_c_nxt;

  logic a_rdy, b_rdy, c_rdy;

  always_comb begin
    a_ext = pra_pkg::angle_ext_t'(angle);
    if (a_ext >= pra_pkg::HALF_TURN_A) begin
      a_mod = a_ext - pra_pkg::FULL_TURN_A;
    end else if (a_ext < -pra_pkg::HALF_TURN_A) begin
      a_mod = a_ext + pra_pkg::FULL_TURN_A;
    end else begin
      a_mod = a_ext;
    end
    flip   = 1'b0;
    a_fold = a_mod;
    if (a_mod > pra_pkg::QUARTER_TURN_A) begin
      flip   = 1'b1;
      a_fold = a_mod - pra_pkg::HALF_TURN_A;
    end else if (a_mod < -pra_pkg::QUARTER_TURN_A) begin
      flip   = 1'b1;
      a_fold = a_mod + pra_pkg::HALF_TURN_A;
    end
    xa_nxt = flip ? -pra_pkg::coord_ext_t'(up_x) : pra_pkg::coord_ext_t'(up_x);
    ya_nxt = flip ? -pra_pkg::coord_ext_t'(up_y) : pra_pkg::coord_ext_t'(up_y);
    za_nxt = pra_pkg::zang_t'(a_fold) <<< pra_pkg::ANGLE_SHIFT;
  end

  always_comb begin
    xp_nxt = pra_pkg::prod_t'(xa_r) * pra_pkg::prod_t'(pra_pkg::GAIN_S);
    yp_nxt = pra_pkg::prod_t'(ya_r) * pra_pkg::prod_t'(pra_pkg::GAIN_S);
  end

  always_comb begin
    data_c_nxt.x = pra_pkg::work_t'((xp_r + pra_pkg::ROUND_IN) >>> pra_pkg::IN_SHIFT);
    data_c_nxt.y = pra_pkg::work_t'((yp_r + pra_pkg::ROUND_IN) >>> pra_pkg::IN_SHIFT);
    data_c_nxt.z = zb_r;
  end

  assign c_rdy    = !c_valid_r || dn_ready;
  assign b_rdy    = !b_valid_r || c_rdy;
  assign a_rdy    = !a_valid_r || b_rdy;
  assign up_ready = a_rdy;
  assign dn_valid = c_valid_r;
  assign dn_data  = data_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_rdy) a_valid_r <= up_valid;
      if (b_rdy) b_valid_r <= a_valid_r;
      if (c_rdy) c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_valid) begin
      xa_r <= xa_nxt;
      ya_r <= ya_nxt;
      za_r <= za_nxt;
    end
    if (b_rdy && a_valid_r) begin
      xp_r <= xp_nxt;
      yp_r <= yp_nxt;
      zb_r <= za_r;
    end
    if (c_rdy && b_valid_r) begin
      data_c_r <= data_c_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pra_cell.sv]
`default_nettype none

// One CORDIC micro-rotation with its own pipeline register.
module pra_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pra_pkg::shift_t       shamt,
  input  wire pra_pkg::zang_t        atan_val,
  input  wire logic                  up_valid,
  input  wire pra_pkg::cordic_data_t up_data,
  output logic                       up_ready,
  output logic                       dn_valid,
  output pra_pkg::cordic_data_t      dn_data,
  input  wire logic                  dn_ready
);

  logic                  valid_r;
  pra_pkg::cordic_data_t data_r;
  pra_pkg::cordic_data_t data_nxt;
  pra_pkg::work_t        dx, dy;

  always_comb begin
    dx = up_data.y >>> shamt;
    dy = up_data.x >>> shamt;
    // A zero residual angle turns counterclockwise.
    if (!up_data.z[pra_pkg::ZW-1]) begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - atan_val;
    end else begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + atan_val;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pra_finish.sv]
`default_nettype none

// Output stage: rounds back to Q12.12, saturates, and holds the result item.
module pra_finish (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_valid,
  input  wire pra_pkg::cordic_data_t up_data,
  output logic                       up_ready,
  output logic                       out_valid,
  output pra_pkg::coord_t            x_out,
  output pra_pkg::coord_t            y_out,
  output logic                       clamped,
  input  wire logic                  out_ready
);

  localparam pra_pkg::round_t HI = pra_pkg::round_t'(pra_pkg::COORD_MAX);
  localparam pra_pkg::round_t LO = pra_pkg::round_t'(pra_pkg::COORD_MIN);

  logic            valid_r;
  pra_pkg::coord_t x_r, y_r;
  logic            clamped_r;

  pra_pkg::round_t rx, ry;
  pra_pkg::coord_t x_nxt, y_nxt;
  logic            sat_x, sat_y;

  always_comb begin
    rx = pra_pkg::round_t'((up_data.x + pra_pkg::ROUND_OUT) >>> pra_pkg::GUARD_BITS);
    ry = pra_pkg::round_t'((up_data.y + pra_pkg::ROUND_OUT) >>> pra_pkg::GUARD_BITS);
    sat_x = 1'b1;
    sat_y = 1'b1;
    if (rx > HI) begin
      x_nxt = pra_pkg::COORD_MAX;
    end else if (rx < LO) begin
      x_nxt = pra_pkg::COORD_MIN;
    end else begin
      x_nxt = pra_pkg::coord_t'(rx);
      sat_x = 1'b0;
    end
    if (ry > HI) begin
      y_nxt = pra_pkg::COORD_MAX;
    end else if (ry < LO) begin
      y_nxt = pra_pkg::COORD_MIN;
    end else begin
      y_nxt = pra_pkg::coord_t'(ry);
      sat_y = 1'b0;
    end
  end

  assign up_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign clamped   = clamped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      clamped_r <= sat_x || sat_y;
    end
  end

endmodule

`default_nettype wire

[rtl/core/point_rotation_by_angle.sv]
// Point rotation about the origin by a programmable angle.
// cfg_chan carries rotation_angle, a signed angle in 1/128 degree units,
// counterclockwise positive; any 17-bit value is taken modulo a full turn.
// Write it only while no items are in flight; it is always ready.
// in_chan carries one point (x_in, y_in) in signed Q12.12 per item, and
// out_chan returns the rotated point (x_out, y_out) in Q12.12 along with
// clamped, which is set when either coordinate saturated.
// The path from in_chan to out_chan has three front-end stages (angle fold
// and negate, gain multiply, rounding), one cell per micro-rotation (16 with
// the package defaults) and one output register, 20 registers in all.
// Throughput is one item per cycle while out_chan.ready stays high; every
// stage has its own valid bit and the ready chain lets bubbles close up.
// When the receiver stalls, the result holds on out_chan and the pipeline
// keeps filling until every stage is occupied, then in_chan.ready drops.
// Reset (synchronous, rst_n low) empties the pipeline and sets the angle to 0.
`default_nettype none

module point_rotation_by_angle (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pra_cfg_if.sink    cfg_chan,
  pra_in_if.sink     in_chan,
  pra_out_if.source  out_chan
);

  localparam int N = pra_pkg::NUM_STAGES;

  // The angle register. Folding into the working range is done in the front
  // end from this value, so a write takes effect on the next accepted item.
  pra_pkg::angle_t rotation_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_angle_r <= '0;
    end else if (cfg_chan.valid) begin
      rotation_angle_r <= cfg_chan.rotation_angle;
    end
  end

  assign cfg_chan.ready = 1'b1;

  // Links between the front end, the cells and the output stage. Link 0 is
  // the front end's output and link N feeds the output stage.
  logic                  link_valid [N+1];
  logic                  link_ready [N+1];
  pra_pkg::cordic_data_t link_data  [N+1];

  pra_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .angle    (rotation_angle_r),
    .up_valid (in_chan.valid),
    .up_x     (in_chan.x_in),
    .up_y     (in_chan.y_in),
    .up_ready (in_chan.ready),
    .dn_valid (link_valid[0]),
    .dn_data  (link_data[0]),
    .dn_ready (link_ready[0])
  );

  // Each cell performs the micro-rotation for its own stage index, with the
  // shift amount and arctangent fixed at elaboration.
  for (genvar i = 0; i < N; i++) begin : g_cell
    pra_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shamt    (pra_pkg::shift_t'(i)),
      .atan_val (pra_pkg::atan_deg(pra_pkg::shift_t'(i))),
      .up_valid (link_valid[i]),
      .up_data  (link_data[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_data  (link_data[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  pra_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (link_valid[N]),
    .up_data   (link_data[N]),
    .up_ready  (link_ready[N]),
    .out_valid (out_chan.valid),
    .x_out     (out_chan.x_out),
    .y_out     (out_chan.y_out),
    .clamped   (out_chan.clamped),
    .out_ready (out_chan.ready)
  );

endmodule

`default_nettype wire

[rtl/core/pra_checker.sv]
`default_nettype none

`include "point_rotation_by_angle_assert.svh"

module pra_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire pra_pkg::coord_t x_out,
  input wire pra_pkg::coord_t y_out,
  input wire logic            clamped
);

  logic [2*pra_pkg::COORD_WIDTH:0] result_bus;
  logic                            x_at_edge;
  logic                            y_at_edge;

  assign result_bus = {x_out, y_out, clamped};
  assign x_at_edge  = (x_out == pra_pkg::COORD_MAX) || (x_out == pra_pkg::COORD_MIN);
  assign y_at_edge  = (y_out == pra_pkg::COORD_MAX) || (y_out == pra_pkg::COORD_MIN);

  // A result that is not taken stays on the port unchanged.
  `PRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_bus))

  // With the receiver ready, every stage can move, so the input side is ready too.
  `PRA_ASSERT_IMPL(a_ready_flows, out_ready, in_ready)

  // A clamped result has at least one coordinate at the edge of the range.
  `PRA_ASSERT_IMPL(a_clamp_edge, out_valid && clamped, x_at_edge || y_at_edge)

endmodule

bind point_rotation_by_angle pra_checker u_pra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .x_out     (out_chan.x_out),
  .y_out     (out_chan.y_out),
  .clamped   (out_chan.clamped)
);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Checks the point rotation block. Each accepted point is rotated by a
// predictor inside this module, and the result waits in a queue until the
// block returns its own result. The queue is checked field by field, in order.
module tb_top;

  // Angle register units: 1/128 degree.
  localparam int UNITS_PER_DEG = 128;
  localparam int ANGLE_45      = 45 * UNITS_PER_DEG;
  localparam int ANGLE_MIN_RAW = -(1 << (pra_pkg::ANGLE_WIDTH - 1));
  localparam int ANGLE_MAX_RAW = (1 << (pra_pkg::ANGLE_WIDTH - 1)) - 1;

  // Items per random phase, and the number of phases.
  localparam int PHASE_ITEMS   = 50;
  localparam int RANDOM_PHASES = 11;

  // The tail wait leaves room beyond the depth of the pipeline.
  localparam int TAIL_CYCLES   = 40;
  // Cycles with no handshake on any channel before the run is called hung.
  // Receiver stalls are short runs drawn from random ready patterns.
  localparam int QUIET_LIMIT   = 2000;

  // Fraction bits that the gain multiply drops.
  localparam int GAIN_DROP     = pra_pkg::GAIN_FRAC - pra_pkg::GUARD_BITS;

  // atan(2^-i) in degrees, scaled by 2^20.
  localparam longint ATAN_Q20 [0:23] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  typedef struct {
    pra_pkg::coord_t x;
    pra_pkg::coord_t y;
    logic            clamped;
  } rotated_point_t;

  logic clk;
  logic rst_n;

  pra_cfg_if cfg_ch ();
  pra_in_if  in_ch ();
  pra_out_if out_ch ();

  point_rotation_by_angle u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_ch),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Results that the block still owes, oldest first.
  rotated_point_t  pending_points[$];
  // The predictor's copy of the angle register.
  pra_pkg::angle_t model_angle;
  int              error_count;
  int              quiet_cycles;
  // Sender pacing: items left in the current burst.
  int              burst_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Round a working coordinate back to Q12.12 and clamp it to the port range.
  // The clamp flag is sticky across the two coordinates of one point.
  function automatic pra_pkg::coord_t saturate_coord(input longint w, inout logic sat);
    longint v;
    v = (w + (longint'(1) <<< (pra_pkg::GUARD_BITS - 1))) >>> pra_pkg::GUARD_BITS;
    if (v > longint'(pra_pkg::COORD_MAX)) begin
      v = longint'(pra_pkg::COORD_MAX);
      sat = 1'b1;
    end
    if (v < longint'(pra_pkg::COORD_MIN)) begin
      v = longint'(pra_pkg::COORD_MIN);
      sat = 1'b1;
    end
    return pra_pkg::coord_t'(v);
  endfunction

  // Predict the rotation of one point by the given register value.
  function automatic rotated_point_t rotate_point(input pra_pkg::coord_t px,
                                                  input pra_pkg::coord_t py,
                                                  input pra_pkg::angle_t ang);
    longint xi, yi, a;
    longint xw, yw, zw, dx, dy;
    logic sat;
    rotated_point_t r;
    xi = px;
    yi = py;
    a  = ang;
    sat = 1'b0;

    // Bring the angle into [-180, 180) degrees, then into [-90, 90] by a
    // half turn, which negates the point exactly.
    a = a % pra_pkg::FULL_TURN;
    if (a < 0) a = a + pra_pkg::FULL_TURN;
    if (a >= pra_pkg::HALF_TURN) a = a - pra_pkg::FULL_TURN;
    if (a > pra_pkg::QUARTER_TURN) begin
      xi = -xi;
      yi = -yi;
      a  = a - pra_pkg::HALF_TURN;
    end else if (a < -pra_pkg::QUARTER_TURN) begin
      xi = -xi;
      yi = -yi;
      a  = a + pra_pkg::HALF_TURN;
    end

    // Remove the CORDIC gain up front; the result carries the guard bits.
    xw = (xi * longint'(pra_pkg::GAIN_Q30) + (longint'(1) <<< (GAIN_DROP - 1))) >>> GAIN_DROP;
    yw = (yi * longint'(pra_pkg::GAIN_Q30) + (longint'(1) <<< (GAIN_DROP - 1))) >>> GAIN_DROP;
    zw = a * (longint'(1) <<< pra_pkg::ANGLE_SHIFT);

    // Micro-rotations; a residual of zero turns counterclockwise.
    for (int i = 0; i < pra_pkg::NUM_STAGES; i++) begin
      dx = yw >>> i;
      dy = xw >>> i;
      if (zw >= 0) begin
        xw = xw - dx;
        yw = yw + dy;
        zw = zw - ATAN_Q20[i];
      end else begin
        xw = xw + dx;
        yw = yw - dy;
        zw = zw + ATAN_Q20[i];
      end
    end

    r.x = saturate_coord(xw, sat);
    r.y = saturate_coord(yw, sat);
    r.clamped = sat;
    return r;
  endfunction

  // A random coordinate: full range, small, mid-sized, or close to a limit.
  function automatic pra_pkg::coord_t pick_coord();
    pra_pkg::coord_t c;
    case ($urandom_range(0, 3))
      0: c = pra_pkg::coord_t'($urandom);
      1: c = pra_pkg::coord_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      2: c = pra_pkg::coord_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          c = pra_pkg::COORD_MAX - pra_pkg::coord_t'($urandom_range(0, 15));
        end else begin
          c = pra_pkg::COORD_MIN + pra_pkg::coord_t'($urandom_range(0, 15));
        end
      end
    endcase
    return c;
  endfunction

  // Send one point. Called at a falling edge; returns at a falling edge.
  // The sender works in bursts: when a burst runs out it may drop valid
  // before it starts the next one.
  task automatic send_point(input pra_pkg::coord_t px, input pra_pkg::coord_t py);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.x_in  <= px;
    in_ch.y_in  <= py;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_points.push_back(rotate_point(px, py, model_angle));
    burst_left--;
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_points();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the angle register while the block holds no item. The block makes
  // exactly one result per item, so an empty queue means an empty pipeline.
  task automatic write_angle(input pra_pkg::angle_t ang);
    drain_points();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.rotation_angle <= ang;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    model_angle = ang;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Coordinate extremes at 45 degrees, where the largest points saturate.
  task automatic test_point_extremes();
    write_angle(pra_pkg::angle_t'(ANGLE_45));
    send_point('0, '0);
    send_point(pra_pkg::COORD_MAX, pra_pkg::COORD_MAX);
    send_point(pra_pkg::COORD_MIN, pra_pkg::COORD_MIN);
    send_point(pra_pkg::COORD_MIN, pra_pkg::COORD_MAX);
    send_point(pra_pkg::COORD_MAX, pra_pkg::COORD_MIN);
    send_point(pra_pkg::coord_t'(1), pra_pkg::coord_t'(0));
    send_point(pra_pkg::coord_t'(-1), pra_pkg::coord_t'(-1));
  endtask

  // Angles at and around the fold points and the register extremes,
  // including values past a full turn that must wrap.
  task automatic test_angle_folding();
    int fold_angles[12];
    fold_angles = '{0, pra_pkg::QUARTER_TURN, pra_pkg::QUARTER_TURN + 1,
                    -pra_pkg::QUARTER_TURN - 1, pra_pkg::HALF_TURN - 1,
                    pra_pkg::HALF_TURN, -pra_pkg::HALF_TURN, pra_pkg::FULL_TURN,
                    -pra_pkg::FULL_TURN, ANGLE_MAX_RAW, ANGLE_MIN_RAW, -1};
    foreach (fold_angles[k]) begin
      write_angle(pra_pkg::angle_t'(fold_angles[k]));
      send_point(pra_pkg::coord_t'(100 << 12), pra_pkg::coord_t'(-(37 << 12)));
    end
  endtask

  // Random points under a series of angles: mostly within the nominal
  // range, sometimes any register pattern, sometimes exact quarter turns.
  task automatic test_random_rotation();
    pra_pkg::angle_t ang;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: ang = pra_pkg::angle_t'($urandom);
        1: ang = pra_pkg::angle_t'(pra_pkg::QUARTER_TURN * (int'($urandom_range(0, 8)) - 4));
        default: begin
          ang = pra_pkg::angle_t'(int'($urandom_range(0, 2 * pra_pkg::FULL_TURN)) -
                                  pra_pkg::FULL_TURN);
        end
      endcase
      write_angle(ang);
      repeat (PHASE_ITEMS) send_point(pick_coord(), pick_coord());
    end
  endtask

  // The receiver takes a new 32-bit ready pattern each time the last one
  // runs out: always ready, random, mostly ready, or mostly stalled.
  logic [31:0] ready_pattern;
  int          pattern_left;

  initial begin
    ready_pattern = '1;
    pattern_left  = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = $urandom;
          2: ready_pattern = $urandom | $urandom;
          default: ready_pattern = $urandom & $urandom;
        endcase
        pattern_left = 32;
      end
      out_ch.ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
      pattern_left--;
    end
  end

  // Compare every returned result with the oldest expectation.
  always @(posedge clk) begin
    rotated_point_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("result with no point outstanding: x_out %0d y_out %0d",
               out_ch.x_out, out_ch.y_out);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_ch.x_out !== want.x) begin
          $error("x_out: expected %0d, got %0d", want.x, out_ch.x_out);
          error_count++;
        end
        if (out_ch.y_out !== want.y) begin
          $error("y_out: expected %0d, got %0d", want.y, out_ch.y_out);
          error_count++;
        end
        if (out_ch.clamped !== want.clamped) begin
          $error("clamped: expected %0b, got %0b", want.clamped, out_ch.clamped);
          error_count++;
        end
      end
    end
  end

  // Count cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    error_count           = 0;
    burst_left            = 0;
    model_angle           = '0;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.x_in            = '0;
    in_ch.y_in            = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.rotation_angle = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The register resets to zero: points must come back unturned.
    send_point(pra_pkg::coord_t'(5 << 12), pra_pkg::coord_t'(-(3 << 12)));
    test_point_extremes();
    test_angle_folding();
    test_random_rotation();

    // Let any stray result show up before the verdict.
    drain_points();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
